/* src/bss_pkg.sv */
// Package: shared types, constants and helpers for the bounded set store.
`default_nettype none
package bss_pkg;

  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = ($clog2(CAPACITY + 1) > 5) ? $clog2(CAPACITY + 1) : 5;

  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_DEL   = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_SHWR,
    S_DONE
  } set_state_t;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] element;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic       present;
    logic [4:0] fill;
  } out_t;

  // Sign-extend the input element, then keep the stored width.
  function automatic elem_t to_elem(input logic signed [31:0] element);
    logic signed [63:0] wide;
    wide = 64'(element);
    return wide[ELEM_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/bounded_set_store.sv */
// Bounded set store: packed array of distinct elements with a sequential scan unit.
//
// Input channel in_valid/in_stall/in_data carries an operation (check, add,
// delete) and an element. Each transfer produces exactly one result on
// out_valid/out_stall/out_data: a status, whether the element was held
// before, and the fill count after the operation.
// One item is worked on at a time; in_stall is high while it is in flight.
// The entries sit in a single-port memory scanned by one comparator; each
// held entry visited is read, then compared. A delete then moves each later
// entry down by one slot, reading it and then writing it.
// The next input is taken in the cycle after the result is issued, and the
// single memory port sets the rate.
// A finished result waits in an output register, so the next item may be
// taken while the receiver stalls; a second result waits until it is taken.
// Reset empties the set and drops any pending result; no clearing pass is
// needed since data from slots at or above the fill count is never used.
`default_nettype none
module bounded_set_store import bss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  set_state_t state_r, state_nxt;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [1:0]       mode_r, mode_nxt;
  elem_t            elem_r, elem_nxt;
  logic             held_r, held_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  elem_t            mem [CAPACITY];
  elem_t            rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  elem_t            wr_data;
  logic             wr_en;

  logic [CNT_W-1:0] idx_inc;
  logic             accept_in;
  logic             out_free;
  logic             full;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign accept_in = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (occ_r >= CNT_W'(CAPACITY));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (idx_r >= occ_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data_r == elem_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DECIDE: begin
        if (mode_r == MODE_DEL && held_r) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (idx_inc < occ_r) begin
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHWR: begin
        state_nxt = S_SHIFT;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    mode_nxt      = mode_r;
    elem_nxt      = elem_r;
    held_nxt      = held_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = idx_r[ADDR_W-1:0];
    wr_addr       = idx_r[ADDR_W-1:0];
    wr_data       = rd_data_r;
    wr_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          idx_nxt    = '0;
          mode_nxt   = in_data.mode;
          elem_nxt   = to_elem(in_data.element);
          held_nxt   = 1'b0;
          status_nxt = STAT_OK;
        end
      end
      S_READ: begin
        rd_addr = idx_r[ADDR_W-1:0];
      end
      S_CMP: begin
        if (rd_data_r == elem_r) begin
          held_nxt = 1'b1;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_DECIDE: begin
        case (mode_r)
          MODE_ADD: begin
            if (held_r) begin
              status_nxt = STAT_DUP;
            end else if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              // append at the end of the packed array
              wr_en   = 1'b1;
              wr_addr = occ_r[ADDR_W-1:0];
              wr_data = elem_r;
              occ_nxt = occ_r + CNT_W'(1);
            end
          end
          MODE_DEL: begin
            if (!held_r) begin
              status_nxt = STAT_NOTFOUND;
            end
          end
          default: begin
            status_nxt = STAT_OK;
          end
        endcase
      end
      S_SHIFT: begin
        if (idx_inc < occ_r) begin
          rd_addr = idx_inc[ADDR_W-1:0];
        end else begin
          occ_nxt = occ_r - CNT_W'(1);
        end
      end
      S_SHWR: begin
        // move the later entry down one slot
        wr_en   = 1'b1;
        wr_addr = idx_r[ADDR_W-1:0];
        wr_data = rd_data_r;
        idx_nxt = idx_inc;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = status_r;
          out_data_nxt.present = held_r;
          out_data_nxt.fill    = occ_r[4:0];
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    mode_r     <= mode_nxt;
    elem_r     <= elem_nxt;
    held_r     <= held_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire
